@@ rtl/biq_pkg.sv @@
// shared constants and types for the biquad filter
package biq_pkg;

	// default widths, samples Q1.(w-1), coefficients Q4.(w-4)
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF   = 24;

	localparam int NUM_COEFS   = 5;
	localparam int CFG_INDEX_W = 3;

	// register index, also the tap that each coefficient multiplies
	typedef enum logic [CFG_INDEX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_idx_t;

	// one configuration write as seen by the register bank
	typedef struct packed {
		logic                   en;
		logic [CFG_INDEX_W-1:0] index;
	} cfg_wr_t;

endpackage

@@ rtl/biq_coef_regs.sv @@
// coefficient register bank written through the configuration port
module biq_coef_regs #(
	parameter int COEF_WIDTH = biq_pkg::COEF_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  biq_pkg::cfg_wr_t                             wr,
	input  logic [COEF_WIDTH-1:0]                        wr_data,
	output logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0] coefs
);
	import biq_pkg::*;

	// unity gain through b0 after reset
	localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(1) << (COEF_WIDTH - 4);
	// whole bank after reset, b0 sits in the lowest slot
	localparam logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] BANK_RESET =
		{{((NUM_COEFS - 1) * COEF_WIDTH){1'b0}}, B0_RESET};

	logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= BANK_RESET;
		end else if (wr.en) begin
			unique case (coef_idx_t'(wr.index))
				COEF_B0: coef_q[COEF_B0] <= wr_data;
				COEF_B1: coef_q[COEF_B1] <= wr_data;
				COEF_B2: coef_q[COEF_B2] <= wr_data;
				COEF_A1: coef_q[COEF_A1] <= wr_data;
				COEF_A2: coef_q[COEF_A2] <= wr_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign coefs = coef_q;

endmodule

@@ rtl/biq_mac.sv @@
// five-tap multiply-accumulate with rounding and saturation
module biq_mac #(
	parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
	input  logic [biq_pkg::NUM_COEFS-1:0][SAMPLE_WIDTH-1:0] taps,
	input  logic [biq_pkg::NUM_COEFS-1:0][COEF_WIDTH-1:0]   coefs,
	output logic [SAMPLE_WIDTH-1:0]                         y
);
	import biq_pkg::*;

	localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + 3;
	localparam int FRAC   = COEF_WIDTH - 4;
	localparam int RES_W  = ACC_W - FRAC;

	localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [RES_W-1:0] RES_MAX =
		RES_W'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
	localparam logic signed [RES_W-1:0] RES_MIN =
		RES_W'($signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}));

	logic signed [NUM_COEFS-1:0][PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]                 acc;
	logic signed [RES_W-1:0]                 res;

	always_comb begin
		acc = RND;
		for (int i = 0; i < NUM_COEFS; i++) begin
			prod[i] = $signed(taps[i]) * $signed(coefs[i]);
			// feedback taps are subtracted
			if (i >= int'(COEF_A1)) begin
				acc = acc - ACC_W'($signed(prod[i]));
			end else begin
				acc = acc + ACC_W'($signed(prod[i]));
			end
		end
	end

	// floor of the rounded sum at output precision
	assign res = $signed(acc[ACC_W-1:FRAC]);

	always_comb begin
		priority if (res > RES_MAX) begin
			y = RES_MAX[SAMPLE_WIDTH-1:0];
		end else if (res < RES_MIN) begin
			y = RES_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y = res[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

@@ rtl/biquad_iir_filter.sv @@
// biquad IIR filter, direct form I, top level
// Second-order IIR section in direct form I: each accepted sample x gives one
// sample y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded to nearest (ties
// upward) and saturated to the sample width; the saturated value feeds the
// output history. Samples are signed Q1.(SAMPLE_WIDTH-1), coefficients signed
// Q4.(COEF_WIDTH-4) at register indexes b0=0, b1=1, b2=2, a1=3, a2=4; other
// indexes are ignored. Reset gives b0 = 1.0, the rest zero and a cleared
// history. Throughput is one sample per clock unless the output stalls; a
// transaction passes an input register and a result register, with the
// five parallel multiplies, the accumulator, rounding and saturation between
// them. That path, closing back into the output history, sets the clock
// rate. With a result held on a stalled output, only an empty input register
// takes a sample. Coefficients should only be written while the filter is idle.
module biquad_iir_filter #(
	parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [SAMPLE_WIDTH-1:0]         sample_in,
	// sample output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [SAMPLE_WIDTH-1:0]         sample_out,
	// coefficient writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [biq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [COEF_WIDTH-1:0]           cfg_data
);
	import biq_pkg::*;

	// input register
	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] x_s1;
	// result register
	logic                    valid_s2;
	logic [SAMPLE_WIDTH-1:0] y_s2;
	// filter history
	logic [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;

	logic                                 in_take;
	logic                                 advance;
	logic [SAMPLE_WIDTH-1:0]              y_next;
	logic [NUM_COEFS-1:0][SAMPLE_WIDTH-1:0] taps;
	logic [NUM_COEFS-1:0][COEF_WIDTH-1:0]   coefs;
	cfg_wr_t                              cfg_wr;

	// register bank is always able to take a write
	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;

	biq_coef_regs #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_coef_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cfg_wr),
		.wr_data (cfg_data),
		.coefs   (coefs)
	);

	// line up each tap with its coefficient
	always_comb begin
		taps          = '0;
		taps[COEF_B0] = x_s1;
		taps[COEF_B1] = x1_q;
		taps[COEF_B2] = x2_q;
		taps[COEF_A1] = y1_q;
		taps[COEF_A2] = y2_q;
	end

	biq_mac #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_mac (
		.taps  (taps),
		.coefs (coefs),
		.y     (y_next)
	);

	// the sample in the input register moves on when the result register is
	// free or is being emptied in this cycle
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_s1 <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2 <= y_next;
		end
	end

	// history shifts exactly when a result is produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (advance) begin
			x2_q <= x1_q;
			x1_q <= x_s1;
			y2_q <= y1_q;
			y1_q <= y_next;
		end
	end

	assign out_valid  = valid_s2;
	assign sample_out = y_s2;

`ifndef NO_ASSERTIONS
	// the result shown is the one that entered the output history
	a_result_is_history: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid && (sample_out == y1_q))
		else $error("result register and output history disagree");

	// the input history takes the sample that was just processed
	a_input_history: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (x1_q == $past(x_s1)))
		else $error("input history did not take the processed sample");

	// a held sample in the input register is neither lost nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(x_s1))
		else $error("held input sample lost or changed");
`endif

endmodule

@@ bench/biquad_iir_filter_tb.sv @@
// self-checking testbench for the direct form I biquad filter
module biquad_iir_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import biq_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int CW = COEF_WIDTH_DEF;
	// coefficient fraction bits, Q4.(CW-4)
	localparam int FRAC = CW - 4;
	localparam int Q_ONE = 1 << FRAC;
	localparam int COEF_MAX = (1 << (CW - 1)) - 1;
	localparam int COEF_MIN = -(1 << (CW - 1));
	localparam int SAMP_MAX = (1 << (SW - 1)) - 1;
	localparam int SAMP_MIN = -(1 << (SW - 1));
	localparam longint SAT_HI = (longint'(1) << (SW - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	// highest index the config port can carry; the ones above COEF_A2 are unused
	localparam int IDX_TOP = (1 << CFG_INDEX_W) - 1;
	// cycles to wait after the last result before touching the coefficients
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [SW-1:0] sample_in;
	logic out_valid;
	logic out_stall;
	logic [SW-1:0] sample_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CW-1:0] cfg_data;

	// local copy of the filter: coefficients and both delay lines
	logic signed [CW-1:0] coef_bank [NUM_COEFS];
	logic signed [SW-1:0] x_prev1, x_prev2, y_prev1, y_prev2;

	// filtered samples still owed by the filter, oldest first
	logic [SW-1:0] expected_samples [$];
	logic [SW-1:0] want;

	int send_idle_pct;
	int stall_pct;
	int mismatches;

	biquad_iir_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// one filter step: five exact products summed wide, half an output lsb
	// added, floored back to sample precision, then clamped; the clamped value
	// is what enters the output history
	function automatic logic [SW-1:0] filter_step(input logic [SW-1:0] x);
		longint acc;
		longint y;
		acc = longint'($signed(x)) * longint'(coef_bank[COEF_B0])
			+ longint'(x_prev1) * longint'(coef_bank[COEF_B1])
			+ longint'(x_prev2) * longint'(coef_bank[COEF_B2])
			- longint'(y_prev1) * longint'(coef_bank[COEF_A1])
			- longint'(y_prev2) * longint'(coef_bank[COEF_A2]);
		acc = acc + (longint'(1) <<< (FRAC - 1));
		// arithmetic shift floors, so ties go towards plus infinity
		y = acc >>> FRAC;
		if (y > SAT_HI)
			y = SAT_HI;
		if (y < SAT_LO)
			y = SAT_LO;
		x_prev2 = x_prev1;
		x_prev1 = $signed(x);
		y_prev2 = y_prev1;
		y_prev1 = y[SW-1:0];
		return y[SW-1:0];
	endfunction

	// result side: random back-pressure and in-order comparison
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected output transaction, sample_out %0d",
						$realtime, $signed(sample_out));
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: sample_out mismatch, expected %0d got %0d",
							$realtime, $signed(want), $signed(sample_out));
				end
			end
		end
	end

	// offer one sample, with random idle cycles ahead of it; valid is left
	// high afterwards so back-to-back transactions never toggle it in one step
	task automatic send_sample(input logic [SW-1:0] x);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
		expected_samples.push_back(filter_step(x));
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_idle();
		int n;
		in_valid <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && expected_samples.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; cfg_valid stays high for a following write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		// unused indexes are dropped by the filter
		if (idx < NUM_COEFS)
			coef_bank[idx] = val;
	endtask

	task automatic load_coefs(input logic [CW-1:0] b0, input logic [CW-1:0] b1,
			input logic [CW-1:0] b2, input logic [CW-1:0] a1, input logic [CW-1:0] a2);
		wait_idle();
		write_reg(COEF_B0, b0);
		write_reg(COEF_B1, b1);
		write_reg(COEF_B2, b2);
		write_reg(COEF_A1, a1);
		write_reg(COEF_A2, a2);
		cfg_valid <= 1'b0;
	endtask

	// coefficient picker: full range, realistic audio sizes, or corner values
	function automatic logic [CW-1:0] rand_coef(input int kind, input bit feedback_one);
		int span;
		case (kind)
			0: begin
				return CW'($urandom());
			end
			1: begin
				span = feedback_one ? 2 * Q_ONE : Q_ONE;
				return CW'(int'($urandom_range(2 * span)) - span);
			end
			default: begin
				case ($urandom_range(5))
					0: return CW'(COEF_MAX);
					1: return CW'(COEF_MIN);
					2: return CW'(Q_ONE);
					3: return CW'(-Q_ONE);
					4: return CW'(1);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	// mostly full-scale noise, with quiet passages and rail values mixed in
	function automatic logic [SW-1:0] rand_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return SW'(SAMP_MAX);
					1: return SW'(SAMP_MIN);
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return SW'(int'($urandom_range(2000)) - 1000);
			default: return SW'($urandom());
		endcase
	endfunction

	// reset coefficients give b0 = 1.0, so the output must copy the input
	task automatic test_passthrough();
		send_sample(SW'(SAMP_MAX));
		send_sample(SW'(SAMP_MIN));
		send_sample('0);
		send_sample('1);
		send_sample(24'h555555);
		send_sample(24'haaaaaa);
	endtask

	// b0 of one lsb scales by 2^-FRAC: halves must round upwards, both signs
	task automatic test_rounding();
		load_coefs(CW'(1), '0, '0, '0, '0);
		send_sample(SW'(1 << (FRAC - 1)));
		send_sample(SW'(-(1 << (FRAC - 1))));
		send_sample(SW'((1 << (FRAC - 1)) - 1));
		send_sample(SW'(-(1 << (FRAC - 1)) - 1));
		send_sample(SW'(SAMP_MAX));
	endtask

	// largest gains drive the sum past both rails
	task automatic test_saturation();
		load_coefs(CW'(COEF_MAX), '0, '0, '0, '0);
		send_sample(SW'(SAMP_MAX));
		send_sample(SW'(SAMP_MIN));
		load_coefs(CW'(COEF_MIN), '0, '0, '0, '0);
		send_sample(SW'(SAMP_MIN));
		send_sample(SW'(SAMP_MAX));
	endtask

	// impulse through every tap, then a runaway feedback loop whose clamped
	// output has to be what is fed back
	task automatic test_feedback();
		load_coefs(CW'(Q_ONE / 2), CW'(Q_ONE / 4), CW'(-Q_ONE / 4),
			CW'(-(3 * Q_ONE) / 2), CW'((3 * Q_ONE) / 4));
		send_sample(SW'(SAMP_MAX));
		repeat (5) send_sample('0);
		load_coefs(CW'(Q_ONE), '0, '0, CW'(COEF_MIN), CW'(COEF_MAX));
		send_sample(SW'(1000));
		send_sample('0);
		send_sample('0);
	endtask

	// writes to the unused indexes must leave the coefficients alone
	task automatic test_unused_index();
		int idx;
		wait_idle();
		for (idx = NUM_COEFS; idx <= IDX_TOP; idx++)
			write_reg(CFG_INDEX_W'(idx), CW'($urandom()));
		cfg_valid <= 1'b0;
		send_sample(SW'(SAMP_MAX));
		send_sample(SW'(12345));
	endtask

	// three idling regimes, four coefficient sets in each
	task automatic test_random();
		int phase;
		int seg;
		int kind;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					stall_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					stall_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				kind = (phase * 4 + seg) % 3;
				load_coefs(rand_coef(kind, 0), rand_coef(kind, 0), rand_coef(kind, 0),
					rand_coef(kind, 1), rand_coef(kind, 0));
				repeat (48) send_sample(rand_sample());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		send_idle_pct = 20;
		stall_pct = 55;
		// state after reset
		coef_bank[COEF_B0] = CW'(Q_ONE);
		coef_bank[COEF_B1] = '0;
		coef_bank[COEF_B2] = '0;
		coef_bank[COEF_A1] = '0;
		coef_bank[COEF_A2] = '0;
		x_prev1 = '0;
		x_prev2 = '0;
		y_prev1 = '0;
		y_prev2 = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_rounding();
		test_saturation();
		test_feedback();
		test_unused_index();
		test_random();

		// drain, then watch a little longer for stray output transactions
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/biq_pkg.sv
rtl/biq_coef_regs.sv
rtl/biq_mac.sv
rtl/biquad_iir_filter.sv
bench/biquad_iir_filter_tb.sv
